@@ rtl/core/repulsive_potential_field_assert.svh @@
// Assertion macros used by the checker file of this block.
`ifndef REPULSIVE_POTENTIAL_FIELD_ASSERT_SVH
`define REPULSIVE_POTENTIAL_FIELD_ASSERT_SVH

// Same-cycle implication, sampled on clk and quiet during reset.
`define RPF_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and quiet during reset.
`define RPF_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/core/rpf_pkg.sv @@
// ----------------------------------------------------------------------------
// rpf_pkg
// Types, constants and tables shared by the repulsive potential field block.
// ----------------------------------------------------------------------------
package rpf_pkg;

	localparam int MAX_BARRIERS = 4096;
	localparam int GRID_ROWS    = 128;
	localparam int GRID_COLS    = 256;

	localparam int ADDR_W   = $clog2(MAX_BARRIERS);
	localparam int CNT_W    = $clog2(MAX_BARRIERS + 1);
	localparam int ROW_W    = 7;
	localparam int COL_W    = 8;
	localparam int ENTRY_W  = ROW_W + COL_W;
	localparam int GAIN_W   = 16;
	localparam int INFL_W   = 6;
	localparam int DIST_W   = 17;           // squared distance of any two cells
	localparam int DIVR_W   = 2 * INFL_W;   // squared distance inside the radius
	localparam int QUOT_W   = 33;           // floor(2^32 / n)
	localparam int DIV_CELLS  = QUOT_W;
	localparam int RAD_W    = QUOT_W + 1;   // radicand padded to whole bit pairs
	localparam int ROOT_W   = 17;
	localparam int SREM_W   = ROOT_W + 2;
	localparam int SQRT_CELLS = RAD_W / 2;
	localparam int PROD_W   = GAIN_W + ROOT_W;
	localparam int ACC_W    = PROD_W + ADDR_W;
	localparam int POT_W    = 32;
	localparam int FRAC_SHIFT = 12;

	localparam logic [1:0] ACT_CLEAR = 2'd0;
	localparam logic [1:0] ACT_ADD   = 2'd1;
	localparam logic [1:0] ACT_QUERY = 2'd2;

	localparam logic [1:0] CLS_FREE    = 2'd0;
	localparam logic [1:0] CLS_BARRIER = 2'd1;
	localparam logic [1:0] CLS_TARGET  = 2'd2;
	localparam logic [1:0] CLS_LISTOP  = 2'd3;

	localparam logic [1:0] REG_GAIN  = 2'd0;
	localparam logic [1:0] REG_INFL  = 2'd1;
	localparam logic [1:0] REG_TROW  = 2'd2;
	localparam logic [1:0] REG_TCOL  = 2'd3;

	// Side information that travels with each barrier term down the chain.
	typedef struct packed {
		logic term;  // barrier lies inside the radius and adds a term
		logic last;  // final barrier of the scan
	} tag_t;

	// floor(65536 / l), with zero for a zero radius.
	function automatic logic [ROOT_W-1:0] inv_influence(input logic [INFL_W-1:0] l);
		logic [ROOT_W-1:0] v;
		case (l)
			6'd1:  v = 17'd65536; 6'd2:  v = 17'd32768; 6'd3:  v = 17'd21845;
			6'd4:  v = 17'd16384; 6'd5:  v = 17'd13107; 6'd6:  v = 17'd10922;
			6'd7:  v = 17'd9362;  6'd8:  v = 17'd8192;  6'd9:  v = 17'd7281;
			6'd10: v = 17'd6553;  6'd11: v = 17'd5957;  6'd12: v = 17'd5461;
			6'd13: v = 17'd5041;  6'd14: v = 17'd4681;  6'd15: v = 17'd4369;
			6'd16: v = 17'd4096;  6'd17: v = 17'd3855;  6'd18: v = 17'd3640;
			6'd19: v = 17'd3449;  6'd20: v = 17'd3276;  6'd21: v = 17'd3120;
			6'd22: v = 17'd2978;  6'd23: v = 17'd2849;  6'd24: v = 17'd2730;
			6'd25: v = 17'd2621;  6'd26: v = 17'd2520;  6'd27: v = 17'd2427;
			6'd28: v = 17'd2340;  6'd29: v = 17'd2259;  6'd30: v = 17'd2184;
			6'd31: v = 17'd2114;  6'd32: v = 17'd2048;  6'd33: v = 17'd1985;
			6'd34: v = 17'd1927;  6'd35: v = 17'd1872;  6'd36: v = 17'd1820;
			6'd37: v = 17'd1771;  6'd38: v = 17'd1724;  6'd39: v = 17'd1680;
			6'd40: v = 17'd1638;  6'd41: v = 17'd1598;  6'd42: v = 17'd1560;
			6'd43: v = 17'd1524;  6'd44: v = 17'd1489;  6'd45: v = 17'd1456;
			6'd46: v = 17'd1424;  6'd47: v = 17'd1394;  6'd48: v = 17'd1365;
			6'd49: v = 17'd1337;  6'd50: v = 17'd1310;  6'd51: v = 17'd1285;
			6'd52: v = 17'd1260;  6'd53: v = 17'd1236;  6'd54: v = 17'd1213;
			6'd55: v = 17'd1191;  6'd56: v = 17'd1170;  6'd57: v = 17'd1149;
			6'd58: v = 17'd1129;  6'd59: v = 17'd1110;  6'd60: v = 17'd1092;
			6'd61: v = 17'd1074;  6'd62: v = 17'd1057;  6'd63: v = 17'd1040;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

@@ rtl/core/rpf_ram.sv @@
// ----------------------------------------------------------------------------
// rpf_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module rpf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

@@ rtl/core/rpf_div_cell.sv @@
// ----------------------------------------------------------------------------
// rpf_div_cell
// One restoring-division step: shifts in a dividend bit, yields a quotient bit.
// ----------------------------------------------------------------------------
module rpf_div_cell (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        dbit,
	input  rpf_pkg::tag_t               tag_in,
	input  logic [rpf_pkg::DIVR_W-1:0]  divisor_in,
	input  logic [rpf_pkg::DIVR_W-1:0]  rem_in,
	input  logic [rpf_pkg::QUOT_W-1:0]  quot_in,
	output rpf_pkg::tag_t               tag_out,
	output logic [rpf_pkg::DIVR_W-1:0]  divisor_out,
	output logic [rpf_pkg::DIVR_W-1:0]  rem_out,
	output logic [rpf_pkg::QUOT_W-1:0]  quot_out
);
	import rpf_pkg::*;

	logic [DIVR_W:0] trial;
	logic            fits;

	assign trial = {rem_in, dbit};
	assign fits  = trial >= {1'b0, divisor_in};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_out <= '0;
		end else begin
			tag_out <= tag_in;
		end
	end

	always_ff @(posedge clk) begin
		divisor_out <= divisor_in;
		if (fits) begin
			rem_out <= DIVR_W'(trial - {1'b0, divisor_in});
		end else begin
			rem_out <= trial[DIVR_W-1:0];
		end
		quot_out <= {quot_in[QUOT_W-2:0], fits};
	end

endmodule

@@ rtl/core/rpf_sqrt_cell.sv @@
// ----------------------------------------------------------------------------
// rpf_sqrt_cell
// One digit-by-digit square root step: consumes two radicand bits per cycle.
// ----------------------------------------------------------------------------
module rpf_sqrt_cell (
	input  logic                        clk,
	input  logic                        arst_n,
	input  rpf_pkg::tag_t               tag_in,
	input  logic [rpf_pkg::RAD_W-1:0]   rad_in,
	input  logic [rpf_pkg::SREM_W-1:0]  rem_in,
	input  logic [rpf_pkg::ROOT_W-1:0]  root_in,
	output rpf_pkg::tag_t               tag_out,
	output logic [rpf_pkg::RAD_W-1:0]   rad_out,
	output logic [rpf_pkg::SREM_W-1:0]  rem_out,
	output logic [rpf_pkg::ROOT_W-1:0]  root_out
);
	import rpf_pkg::*;

	logic [SREM_W+1:0] cur;
	logic [SREM_W+1:0] trial;
	logic              fits;

	assign cur   = {rem_in, rad_in[RAD_W-1 -: 2]};
	assign trial = {{(SREM_W - ROOT_W){1'b0}}, root_in, 2'b01};
	assign fits  = cur >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_out <= '0;
		end else begin
			tag_out <= tag_in;
		end
	end

	always_ff @(posedge clk) begin
		rad_out <= {rad_in[RAD_W-3:0], 2'b00};
		if (fits) begin
			rem_out  <= SREM_W'(cur - trial);
			root_out <= {root_in[ROOT_W-2:0], 1'b1};
		end else begin
			rem_out  <= cur[SREM_W-1:0];
			root_out <= {root_in[ROOT_W-2:0], 1'b0};
		end
	end

endmodule

@@ rtl/core/repulsive_potential_field.sv @@
// ----------------------------------------------------------------------------
// repulsive_potential_field
// Barrier list and repulsive potential evaluator for a grid of cells.
// ----------------------------------------------------------------------------
// Usage: a command beat is taken when start is high and busy is low. Clear,
// add and the unused action code answer in the next cycle with class 3 on the
// result ports, marked by done for exactly one cycle; busy stays low, so the
// next command may follow at once. A query of the target cell answers in the
// same way with class 2, and a query outside the grid or of an empty list
// with class 0. Any other query scans the barrier list: one stored barrier
// is read from the barrier RAM per cycle and its term travels down a chain
// of 33 division cells and 17 square root cells, then a multiplier and the
// accumulator. The result of a query is registered when the term of the last
// barrier reaches the accumulator, with busy high until done is shown.
// Configuration beats are always taken (cfg_ready is high) and must only be
// sent while the block is idle.
// The receiver cannot stall: done marks each result for one cycle only.
// Reset empties the list and loads the register defaults; the RAM contents
// are left as they are, since only entries below the count are ever read.
// ----------------------------------------------------------------------------
module repulsive_potential_field (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [1:0]  action,
	input  logic [6:0]  row,
	input  logic [7:0]  col,
	output logic        busy,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	output logic        done,
	output logic [31:0] potential,
	output logic [1:0]  cell_class,
	output logic        list_full
);
	import rpf_pkg::*;

	typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_DRAIN} state_t;

	// Configuration registers.
	logic [GAIN_W-1:0] gain_q;
	logic [INFL_W-1:0] infl_q;
	logic [ROW_W-1:0]  trow_q;
	logic [COL_W-1:0]  tcol_q;

	// Control state.
	state_t            state_q;
	logic [CNT_W-1:0]  count_q;
	logic [ADDR_W-1:0] addr_q;
	logic [ROW_W-1:0]  qrow_q;
	logic [COL_W-1:0]  qcol_q;
	logic              hit_q;
	logic [ACC_W-1:0]  acc_q;

	logic accept;
	logic in_grid;
	logic issue;
	logic issue_last;

	assign cfg_ready = 1'b1;
	assign busy      = state_q != ST_IDLE;
	assign accept    = start && !busy;
	assign in_grid   = (32'(row) < 32'(GRID_ROWS)) && (32'(col) < 32'(GRID_COLS));
	assign issue     = state_q == ST_SCAN;
	assign issue_last = issue && ({1'b0, addr_q} == CNT_W'(count_q - 1'b1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q <= 16'd10240;
			infl_q <= 6'd15;
			trow_q <= '0;
			tcol_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_GAIN: gain_q <= cfg_data;
				REG_INFL: infl_q <= cfg_data[INFL_W-1:0];
				REG_TROW: trow_q <= cfg_data[ROW_W-1:0];
				REG_TCOL: tcol_q <= cfg_data[COL_W-1:0];
				default: ;
			endcase
		end
	end

	// Barrier RAM: written by adds, read once per scan cycle.
	logic                ram_we;
	logic [ENTRY_W-1:0]  ram_rdata;

	assign ram_we = accept && action == ACT_ADD && in_grid
		&& count_q < CNT_W'(MAX_BARRIERS);

	rpf_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(MAX_BARRIERS)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (count_q[ADDR_W-1:0]),
		.wdata ({row, col}),
		.raddr (addr_q),
		.rdata (ram_rdata)
	);

	// Stage 1 follows the RAM read; stage 2 forms the squared distance.
	logic               vld_s1;
	logic               last_s1;
	tag_t               tag_s2;
	logic [DIVR_W-1:0]  dsq_s2;
	logic signed [ROW_W:0] dr;
	logic signed [COL_W:0] dc;
	logic [DIST_W-1:0]  dsq;
	logic [DIVR_W-1:0]  lim2;
	logic               zero_dist;

	assign dr   = $signed({1'b0, qrow_q}) - $signed({1'b0, ram_rdata[ENTRY_W-1:COL_W]});
	assign dc   = $signed({1'b0, qcol_q}) - $signed({1'b0, ram_rdata[COL_W-1:0]});
	assign dsq  = DIST_W'(dr * dr) + DIST_W'(dc * dc);
	assign lim2 = DIVR_W'(infl_q * infl_q);
	assign zero_dist = vld_s1 && dsq == '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			last_s1 <= 1'b0;
			tag_s2  <= '0;
		end else begin
			vld_s1      <= issue;
			last_s1     <= issue_last;
			tag_s2.term <= vld_s1 && dsq != '0 && dsq < DIST_W'(lim2);
			tag_s2.last <= vld_s1 && last_s1;
		end
	end

	always_ff @(posedge clk) begin
		dsq_s2 <= dsq[DIVR_W-1:0];
	end

	// Division chain: floor(2^32 / n), one quotient bit per cell.
	tag_t              div_tag  [DIV_CELLS+1];
	logic [DIVR_W-1:0] div_dvs  [DIV_CELLS+1];
	logic [DIVR_W-1:0] div_rem  [DIV_CELLS+1];
	logic [QUOT_W-1:0] div_quot [DIV_CELLS+1];

	assign div_tag[0]  = tag_s2;
	assign div_dvs[0]  = dsq_s2;
	assign div_rem[0]  = '0;
	assign div_quot[0] = '0;

	for (genvar k = 0; k < DIV_CELLS; k++) begin : g_div
		rpf_div_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.dbit        ((k == 0) ? 1'b1 : 1'b0),
			.tag_in      (div_tag[k]),
			.divisor_in  (div_dvs[k]),
			.rem_in      (div_rem[k]),
			.quot_in     (div_quot[k]),
			.tag_out     (div_tag[k+1]),
			.divisor_out (div_dvs[k+1]),
			.rem_out     (div_rem[k+1]),
			.quot_out    (div_quot[k+1])
		);
	end

	// Square root chain: floor(sqrt(q)), one root bit per cell.
	tag_t              sq_tag  [SQRT_CELLS+1];
	logic [RAD_W-1:0]  sq_rad  [SQRT_CELLS+1];
	logic [SREM_W-1:0] sq_rem  [SQRT_CELLS+1];
	logic [ROOT_W-1:0] sq_root [SQRT_CELLS+1];

	assign sq_tag[0]  = div_tag[DIV_CELLS];
	assign sq_rad[0]  = {1'b0, div_quot[DIV_CELLS]};
	assign sq_rem[0]  = '0;
	assign sq_root[0] = '0;

	for (genvar k = 0; k < SQRT_CELLS; k++) begin : g_sqrt
		rpf_sqrt_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.tag_in   (sq_tag[k]),
			.rad_in   (sq_rad[k]),
			.rem_in   (sq_rem[k]),
			.root_in  (sq_root[k]),
			.tag_out  (sq_tag[k+1]),
			.rad_out  (sq_rad[k+1]),
			.rem_out  (sq_rem[k+1]),
			.root_out (sq_root[k+1])
		);
	end

	// Stage 3: gain times (1/d - 1/influence), clipped at zero.
	tag_t              tag_s3;
	logic [PROD_W-1:0] prod_s3;
	logic [ROOT_W-1:0] recip;
	logic [ROOT_W-1:0] invl;
	logic [ROOT_W-1:0] diff;

	assign recip = sq_root[SQRT_CELLS];
	assign invl  = inv_influence(infl_q);
	assign diff  = (recip > invl) ? ROOT_W'(recip - invl) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s3 <= '0;
		end else begin
			tag_s3 <= sq_tag[SQRT_CELLS];
		end
	end

	always_ff @(posedge clk) begin
		prod_s3 <= PROD_W'(gain_q * diff);
	end

	// Final sum, seen on the cycle the last term arrives.
	logic [ACC_W-1:0]          acc_sum;
	logic [ACC_W-FRAC_SHIFT-1:0] scaled;

	assign acc_sum = acc_q + (tag_s3.term ? ACC_W'(prod_s3) : '0);
	assign scaled  = acc_sum[ACC_W-1:FRAC_SHIFT];

	// Command sequencer, list count and result registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			count_q    <= '0;
			addr_q     <= '0;
			qrow_q     <= '0;
			qcol_q     <= '0;
			hit_q      <= 1'b0;
			acc_q      <= '0;
			done       <= 1'b0;
			potential  <= '0;
			cell_class <= CLS_LISTOP;
			list_full  <= 1'b0;
		end else begin
			done <= 1'b0;
			if (zero_dist) begin
				hit_q <= 1'b1;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						potential  <= '0;
						cell_class <= CLS_LISTOP;
						list_full  <= 1'b0;
						qrow_q     <= row;
						qcol_q     <= col;
						addr_q     <= '0;
						hit_q      <= 1'b0;
						acc_q      <= '0;
						case (action)
							ACT_CLEAR: begin
								count_q <= '0;
								done    <= 1'b1;
							end
							ACT_ADD: begin
								done <= 1'b1;
								if (in_grid) begin
									if (count_q >= CNT_W'(MAX_BARRIERS)) begin
										list_full <= 1'b1;
									end else begin
										count_q <= CNT_W'(count_q + 1'b1);
									end
								end
							end
							ACT_QUERY: begin
								if (!in_grid) begin
									cell_class <= CLS_FREE;
									done       <= 1'b1;
								end else if (row == trow_q && col == tcol_q) begin
									cell_class <= CLS_TARGET;
									done       <= 1'b1;
								end else if (count_q == '0) begin
									cell_class <= CLS_FREE;
									done       <= 1'b1;
								end else begin
									state_q <= ST_SCAN;
								end
							end
							default: begin
								done <= 1'b1;
							end
						endcase
					end
				end
				ST_SCAN: begin
					addr_q <= ADDR_W'(addr_q + 1'b1);
					if (issue_last) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					acc_q <= acc_sum;
					if (tag_s3.last) begin
						done    <= 1'b1;
						state_q <= ST_IDLE;
						if (hit_q) begin
							cell_class <= CLS_BARRIER;
							potential  <= '0;
						end else begin
							cell_class <= CLS_FREE;
							potential  <= scaled[POT_W] ? {POT_W{1'b1}} : scaled[POT_W-1:0];
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			// Terms that reach the accumulator while issue is still running.
			if (state_q == ST_SCAN) begin
				acc_q <= acc_sum;
			end
		end
	end

endmodule

@@ rtl/core/rpf_checker.sv @@
// ----------------------------------------------------------------------------
// rpf_checker
// Port-level checks on the repulsive potential field block, bound to its top.
// ----------------------------------------------------------------------------
`include "repulsive_potential_field_assert.svh"

module rpf_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic [1:0]  action,
	input logic        busy,
	input logic        done,
	input logic [31:0] potential,
	input logic [1:0]  cell_class,
	input logic        list_full
);
	import rpf_pkg::*;

	`RPF_ASSERT_NOW(a_pot_free_only, done && cell_class != CLS_FREE, potential == '0, "potential on a non-free result")
	`RPF_ASSERT_NOW(a_full_listop, done && list_full, cell_class == CLS_LISTOP, "list_full outside a list operation")
	`RPF_ASSERT_NEXT(a_listop_answer, start && !busy && action != ACT_QUERY, done, "list operation not answered next cycle")
	`RPF_ASSERT_NOW(a_done_idle, done, !busy, "result shown while still busy")

endmodule

bind repulsive_potential_field rpf_checker u_rpf_checker (.*);
